// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, switched off while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication that is also checked during reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: design/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared constants for the script signature-operation counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssc_pkg;

  // Width of the internal saturating counter.
  localparam int COUNT_BITS = 20;

  // Widths of the stream payloads.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_COUNT_W = 20;
  localparam int OUT_TDATA_W = 24;

  // Reset value of the multisig worst-case register.
  localparam logic [7:0] WORST_CASE_RESET = 8'd20;

  // Parser phases.
  localparam logic [1:0] PHASE_OPCODE  = 2'd0;
  localparam logic [1:0] PHASE_LENGTH  = 2'd1;
  localparam logic [1:0] PHASE_PAYLOAD = 2'd2;

  // Opcodes of interest.
  localparam logic [7:0] OP_PUSH_MIN        = 8'h01;
  localparam logic [7:0] OP_PUSH_MAX        = 8'h4b;
  localparam logic [7:0] OP_PUSH_LEN1       = 8'h4c;
  localparam logic [7:0] OP_PUSH_LEN2       = 8'h4d;
  localparam logic [7:0] OP_PUSH_LEN4       = 8'h4e;
  localparam logic [7:0] OP_1               = 8'h51;
  localparam logic [7:0] OP_16              = 8'h60;
  localparam logic [7:0] OP_SMALL_BASE      = 8'h50;
  localparam logic [7:0] OP_SIG_CHECK       = 8'hac;
  localparam logic [7:0] OP_SIG_CHECK_VFY   = 8'had;
  localparam logic [7:0] OP_MULTI_CHECK     = 8'hae;
  localparam logic [7:0] OP_MULTI_CHECK_VFY = 8'haf;
  localparam logic [7:0] OP_INVALID         = 8'hff;

endpackage

// File: design/script_sigop_counter.sv
// ----------------------------------------------------------------------------
// script_sigop_counter
// Streams a script one byte per transaction, skips push payloads and counts
// signature operations; one result per script on its last byte.
// ----------------------------------------------------------------------------
//  Channel  | Direction | tdata (low bit up)          | tuser          | tlast
//  in_      | slave     | script_byte[7:0]            | accurate_mode  | last_byte
//  out_     | master    | sigop_count[19:0], 4'b0 pad | truncated_push | -
//  cfg_     | write     | multisig_worst_case[7:0]    | -              | -
//
//  Throughput is one script byte per cycle while the input does not stall;
//  the parser state update is combinational between the input register and
//  the result register. out_tvalid rises once the last byte has passed from
//  the input register into the result register.
//  Reset (rst_n low, synchronous) clears the parser and reloads the worst
//  case with 20. The input stalls only when a last byte waits in the input
//  register while the result register still holds an untaken result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module script_sigop_counter (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ssc_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] script_byte
  input  logic                             in_tlast,   // last_byte
  input  logic                             in_tuser,   // accurate_mode
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ssc_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [19:0] sigop_count, [23:20] zero
  output logic                             out_tuser,  // truncated_push
  // Configuration.
  input  logic                             cfg_we,
  input  logic [7:0]                       cfg_wdata   // multisig_worst_case
);
  import ssc_pkg::*;

  // Input register.
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       in_acc_r;

  // Parser state.
  logic [1:0]            phase_r,    phase_nxt;
  logic [2:0]            len_left_r, len_left_nxt;
  logic [31:0]           asm_len_r,  asm_len_nxt;
  logic [31:0]           pay_left_r, pay_left_nxt;
  logic [7:0]            prev_op_r,  prev_op_nxt;
  logic [COUNT_BITS-1:0] total_r,    total_nxt;

  // Configuration and result registers.
  logic [7:0]             worst_case_r;
  logic                   out_valid_r;
  logic [OUT_COUNT_W-1:0] out_count_r;
  logic                   out_trunc_r;

  logic                  advance;
  logic                  out_free;
  logic [7:0]            add_amt;
  logic [COUNT_BITS:0]   sum;
  logic [2:0]            len_total;
  logic [2:0]            len_idx;
  logic [2:0]            len_dec;
  logic [31:0]           len_word;
  logic [31:0]           total_ext;

  // Handshake: the stage advances unless a result would overwrite one in waiting.
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && (!in_last_r || out_free);
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
      in_acc_r  <= in_tuser;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worst_case_r <= WORST_CASE_RESET;
    end else if (cfg_we) begin
      worst_case_r <= cfg_wdata;
    end
  end

  // Amount that the current opcode adds to the count.
  always_comb begin
    add_amt = 8'd0;
    if (in_byte_r == OP_SIG_CHECK || in_byte_r == OP_SIG_CHECK_VFY) begin
      add_amt = 8'd1;
    end else if (in_byte_r == OP_MULTI_CHECK || in_byte_r == OP_MULTI_CHECK_VFY) begin
      if (in_acc_r && prev_op_r >= OP_1 && prev_op_r <= OP_16) begin
        add_amt = prev_op_r - OP_SMALL_BASE;
      end else begin
        add_amt = worst_case_r;
      end
    end
  end

  // Saturating add of the opcode's charge.
  assign sum = {1'b0, total_r} + (COUNT_BITS+1)'(add_amt);

  // Length byte position within a PUSHDATA length field.
  always_comb begin
    unique case (prev_op_r)
      OP_PUSH_LEN1: len_total = 3'd1;
      OP_PUSH_LEN2: len_total = 3'd2;
      default:      len_total = 3'd4;
    endcase
  end

  assign len_idx  = len_total - len_left_r;
  assign len_word = asm_len_r | (32'(in_byte_r) << {len_idx[1:0], 3'b000});
  assign len_dec  = (len_left_r != 3'd0) ? len_left_r - 3'd1 : 3'd0;

  // Parser step for one script byte.
  always_comb begin
    phase_nxt    = phase_r;
    len_left_nxt = len_left_r;
    asm_len_nxt  = asm_len_r;
    pay_left_nxt = pay_left_r;
    prev_op_nxt  = prev_op_r;
    total_nxt    = total_r;
    unique case (phase_r)
      PHASE_LENGTH: begin
        asm_len_nxt  = len_word;
        len_left_nxt = len_dec;
        if (len_dec == 3'd0) begin
          if (len_word == 32'd0) begin
            phase_nxt = PHASE_OPCODE;
          end else begin
            pay_left_nxt = len_word;
            phase_nxt    = PHASE_PAYLOAD;
          end
        end
      end
      PHASE_PAYLOAD: begin
        if (pay_left_r != 32'd0) begin
          pay_left_nxt = pay_left_r - 32'd1;
        end
        if (pay_left_r <= 32'd1) begin
          phase_nxt = PHASE_OPCODE;
        end
      end
      default: begin
        total_nxt   = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
        prev_op_nxt = in_byte_r;
        if (in_byte_r >= OP_PUSH_MIN && in_byte_r <= OP_PUSH_MAX) begin
          pay_left_nxt = 32'(in_byte_r);
          phase_nxt    = PHASE_PAYLOAD;
        end else if (in_byte_r >= OP_PUSH_LEN1 && in_byte_r <= OP_PUSH_LEN4) begin
          priority if (in_byte_r == OP_PUSH_LEN1) begin
            len_left_nxt = 3'd1;
          end else if (in_byte_r == OP_PUSH_LEN2) begin
            len_left_nxt = 3'd2;
          end else begin
            len_left_nxt = 3'd4;
          end
          asm_len_nxt = 32'd0;
          phase_nxt   = PHASE_LENGTH;
        end
      end
    endcase
  end

  // Parser state registers; the last byte of a script starts a fresh one.
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && in_last_r)) begin
      phase_r    <= PHASE_OPCODE;
      len_left_r <= 3'd0;
      asm_len_r  <= 32'd0;
      pay_left_r <= 32'd0;
      prev_op_r  <= OP_INVALID;
      total_r    <= '0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      len_left_r <= len_left_nxt;
      asm_len_r  <= asm_len_nxt;
      pay_left_r <= pay_left_nxt;
      prev_op_r  <= prev_op_nxt;
      total_r    <= total_nxt;
    end
  end

  // Result register.
  assign total_ext = 32'(total_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_count_r <= total_ext[OUT_COUNT_W-1:0];
      out_trunc_r <= (phase_nxt != PHASE_OPCODE);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_count_r);
  assign out_tuser  = out_trunc_r;

endmodule

// File: design/ssc_checker.sv
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks for the script signature-operation counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ssc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                             out_tuser
);
  import ssc_pkg::*;

  // A pending result stays offered until it is taken.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // A stalled result keeps its count and flag.
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready,
               $stable(out_tdata) && $stable(out_tuser))

  // The padding above the count is zero while a result is offered.
  `ASSERT_NOW(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[OUT_TDATA_W-1:OUT_COUNT_W] == '0)

  // Reset leaves no result on the output.
  `ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_tvalid)

endmodule

bind script_sigop_counter ssc_checker u_ssc_checker (.*);
